// ----- rtl/core/nearest_breakpoint_map_lookup_assert.svh -----
// assertion macros used by the block's top module
`ifndef NEAREST_BREAKPOINT_MAP_LOOKUP_ASSERT_SVH
`define NEAREST_BREAKPOINT_MAP_LOOKUP_ASSERT_SVH

`ifndef SYNTH

// checked on every rising edge of aclk, off while reset is held
`define NBML_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// checked on every rising edge of aclk, reset included
`define NBML_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`else

`define NBML_ASSERT(label, prop, msg)

`define NBML_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ----- rtl/core/nbml_pkg.sv -----
package nbml_pkg;

    localparam int ROWS = 14;
    localparam int COLS = 12;

    localparam int DEPTH  = ROWS * COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2((ROWS > COLS) ? ROWS : COLS);

    localparam int WORD_W = 16;
    localparam int DIST_W = WORD_W + 1;

    // input word: cell_row, cell_col, cell_value, query_x, query_y
    localparam int S_TDATA_W = 56;
    // result word: map_value, chosen_col, chosen_row
    localparam int M_TDATA_W = 24;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic              take;
        logic [DIST_W-1:0] distance;
    } cmp_result_t;

endpackage

// ----- rtl/core/nbml_dist_unit.sv -----
module nbml_dist_unit (
    input  logic signed [nbml_pkg::WORD_W-1:0] entry,
    input  logic signed [nbml_pkg::WORD_W-1:0] query,
    input  logic        [nbml_pkg::DIST_W-1:0] best_dist,
    input  logic                               first,
    output nbml_pkg::cmp_result_t              result
);

    logic signed [nbml_pkg::DIST_W-1:0] diff;
    logic        [nbml_pkg::DIST_W-1:0] mag;

    // exact difference at one bit wider than the words
    assign diff = {entry[nbml_pkg::WORD_W-1], entry} - {query[nbml_pkg::WORD_W-1], query};
    assign mag  = diff[nbml_pkg::DIST_W-1] ? nbml_pkg::DIST_W'(-diff) : nbml_pkg::DIST_W'(diff);

    // strict less keeps the lower index on a tie
    assign result.take     = first || (mag < best_dist);
    assign result.distance = mag;

endmodule

// ----- rtl/core/nbml_map_mem.sv -----
module nbml_map_mem (
    input  logic                               aclk,
    input  logic                               wr_en,
    input  logic        [nbml_pkg::ADDR_W-1:0] wr_addr,
    input  logic signed [nbml_pkg::WORD_W-1:0] wr_data,
    input  logic                               rd_en,
    input  logic        [nbml_pkg::ADDR_W-1:0] rd_addr,
    output logic signed [nbml_pkg::WORD_W-1:0] rd_data
);

    logic signed [nbml_pkg::WORD_W-1:0] mem [nbml_pkg::DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/nearest_breakpoint_map_lookup.sv -----
// Nearest-breakpoint lookup in a 14 x 12 table of signed 16-bit words.
// Row 0 holds the column breakpoints, column 0 the row breakpoints.
// Input channel s_*: s_tuser is the kind (0 write one cell, 1 lookup).
// A write stores cell_value at [cell_row][cell_col] and gives no result;
// out-of-range addresses are dropped. A lookup gives one result word on
// m_* with the nearest cell and both chosen indices.
// A lookup scans row 0 and then column 0 through one table memory with
// separate write and read ports and one shared distance/compare unit,
// one entry per cycle, then reads the chosen cell. s_tready is high only
// while the sequencer is idle, so one item is in work at a time and the
// next item is accepted only once a lookup has handed its result word to
// the output register.
// The result sits in an output register; a new item may be accepted while
// it waits. If the receiver stalls, the next lookup finishes its scan and
// then holds until the waiting word is taken.
// Reset clears the sequencer and the output valid only; the table content
// is undefined until each cell used by a lookup has been written.
module nearest_breakpoint_map_lookup (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cell_row[3:0], cell_col[7:4], cell_value[23:8], query_x[39:24], query_y[55:40]
    input  logic [nbml_pkg::S_TDATA_W-1:0]    s_tdata,
    // kind[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // map_value[15:0], chosen_col[19:16], chosen_row[23:20]
    output logic [nbml_pkg::M_TDATA_W-1:0]    m_tdata
);

`include "nearest_breakpoint_map_lookup_assert.svh"

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;

    localparam int AW = nbml_pkg::ADDR_W;
    localparam int IW = nbml_pkg::IDX_W;
    localparam int WW = nbml_pkg::WORD_W;
    localparam int DW = nbml_pkg::DIST_W;

    logic [3:0]           in_row;
    logic [3:0]           in_col;
    logic signed [WW-1:0] in_value;
    logic signed [WW-1:0] in_qx;
    logic signed [WW-1:0] in_qy;

    assign in_row   = s_tdata[3:0];
    assign in_col   = s_tdata[7:4];
    assign in_value = s_tdata[23:8];
    assign in_qx    = s_tdata[39:24];
    assign in_qy    = s_tdata[55:40];

    logic [2:0]           state_reg, state_next;
    logic                 iss_active_reg, iss_active_next;
    logic                 iss_phase_reg, iss_phase_next;
    logic [IW-1:0]        iss_idx_reg, iss_idx_next;
    logic [AW-1:0]        iss_addr_reg, iss_addr_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic                 cmp_phase_reg, cmp_phase_next;
    logic [IW-1:0]        cmp_idx_reg, cmp_idx_next;
    logic signed [WW-1:0] qx_reg, qx_next;
    logic signed [WW-1:0] qy_reg, qy_next;
    logic [DW-1:0]        best_d_reg, best_d_next;
    logic [IW-1:0]        best_c_reg, best_c_next;
    logic [IW-1:0]        best_r_reg, best_r_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [nbml_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                 s_fire;
    logic                 wr_en;
    logic                 wr_in_range;
    logic [AW-1:0]        wr_addr;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        fetch_addr;
    logic signed [WW-1:0] rd_data;
    nbml_pkg::cmp_result_t cmp;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    assign wr_in_range = (int'(in_row) < nbml_pkg::ROWS) && (int'(in_col) < nbml_pkg::COLS);
    assign wr_en       = s_fire && (s_tuser == nbml_pkg::KIND_WRITE) && wr_in_range;
    assign wr_addr     = AW'(in_row) * AW'(nbml_pkg::COLS) + AW'(in_col);

    assign fetch_addr = AW'(best_r_reg) * AW'(nbml_pkg::COLS) + AW'(best_c_reg);
    assign rd_en      = iss_active_reg || (state_reg == ST_FETCH);
    assign rd_addr    = (state_reg == ST_FETCH) ? fetch_addr : iss_addr_reg;

    nbml_map_mem u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    nbml_dist_unit u_dist (
        .entry     (rd_data),
        .query     (cmp_phase_reg ? qy_reg : qx_reg),
        .best_dist (best_d_reg),
        .first     (cmp_idx_reg == '0),
        .result    (cmp)
    );

    always_comb begin
        state_next      = state_reg;
        iss_active_next = iss_active_reg;
        iss_phase_next  = iss_phase_reg;
        iss_idx_next    = iss_idx_reg;
        iss_addr_next   = iss_addr_reg;
        cmp_valid_next  = iss_active_reg;
        cmp_phase_next  = iss_phase_reg;
        cmp_idx_next    = iss_idx_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        best_d_next     = best_d_reg;
        best_c_next     = best_c_reg;
        best_r_next     = best_r_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        // issue side: row 0 left to right, then column 0 top to bottom
        if (iss_active_reg) begin
            if (!iss_phase_reg) begin
                if (iss_idx_reg == IW'(nbml_pkg::COLS - 1)) begin
                    iss_phase_next = 1'b1;
                    iss_idx_next   = '0;
                    iss_addr_next  = '0;
                end else begin
                    iss_idx_next  = iss_idx_reg + IW'(1);
                    iss_addr_next = iss_addr_reg + AW'(1);
                end
            end else begin
                if (iss_idx_reg == IW'(nbml_pkg::ROWS - 1)) begin
                    iss_active_next = 1'b0;
                end else begin
                    iss_idx_next  = iss_idx_reg + IW'(1);
                    iss_addr_next = iss_addr_reg + AW'(nbml_pkg::COLS);
                end
            end
        end

        // compare side: one entry a cycle, one read behind the issue
        if (cmp_valid_reg && cmp.take) begin
            best_d_next = cmp.distance;
            if (cmp_phase_reg) begin
                best_r_next = cmp_idx_reg;
            end else begin
                best_c_next = cmp_idx_reg;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_tuser == nbml_pkg::KIND_LOOKUP)) begin
                    state_next      = ST_SCAN;
                    iss_active_next = 1'b1;
                    iss_phase_next  = 1'b0;
                    iss_idx_next    = '0;
                    iss_addr_next   = '0;
                    qx_next         = in_qx;
                    qy_next         = in_qy;
                end
            end
            ST_SCAN: begin
                if (!iss_active_reg && !cmp_valid_reg) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'(best_r_reg), 4'(best_c_reg), rd_data};
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            iss_active_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            iss_active_reg <= iss_active_next;
            cmp_valid_reg  <= cmp_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        iss_phase_reg <= iss_phase_next;
        iss_idx_reg   <= iss_idx_next;
        iss_addr_reg  <= iss_addr_next;
        cmp_phase_reg <= cmp_phase_next;
        cmp_idx_reg   <= cmp_idx_next;
        qx_reg        <= qx_next;
        qy_reg        <= qy_next;
        best_d_reg    <= best_d_next;
        best_c_reg    <= best_c_next;
        best_r_reg    <= best_r_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `NBML_ASSERT(a_scan_only_in_scan,
        (iss_active_reg || cmp_valid_reg) |-> (state_reg == ST_SCAN),
        "scan pipeline busy outside scan state")
    `NBML_ASSERT(a_row0_addr,
        (iss_active_reg && !iss_phase_reg) |-> (iss_addr_reg == AW'(iss_idx_reg)),
        "row 0 address does not follow column index")
    `NBML_ASSERT(a_fetch_in_range,
        (state_reg == ST_FETCH) |-> ((int'(best_c_reg) < nbml_pkg::COLS)
            && (int'(best_r_reg) < nbml_pkg::ROWS)),
        "chosen cell outside table")
    `NBML_ASSERT(a_wait_holds,
        (state_reg == ST_WAIT && m_tvalid_reg && !m_tready) |=> (state_reg == ST_WAIT),
        "result overwritten while stalled")
    `NBML_ASSERT_ALWAYS(a_reset_idle,
        !aresetn |=> (state_reg == ST_IDLE && !m_tvalid_reg),
        "reset does not clear sequencer")

endmodule
